// File: sv/sensor_packet_framer_assert.svh
// assertion macros for the sensor packet framer
`ifndef SENSOR_PACKET_FRAMER_ASSERT_SVH
`define SENSOR_PACKET_FRAMER_ASSERT_SVH

`ifndef SYNTH
// implication checked on every rising clock edge outside reset
`define SPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sensor_packet_framer: assertion failed");
// condition that must never be true outside reset
`define SPF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sensor_packet_framer: forbidden condition seen");
`else
`define SPF_ASSERT(lbl, prop)
`define SPF_NEVER(lbl, cond)
`endif

`endif

// File: sv/spf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned SEED_COUNT   = 5;
  localparam int unsigned SEED_REGS    = 5;
  localparam int unsigned MAX_WIDTH    = 32;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam int unsigned IDX_W        = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned SEED_IDX_W   = (SEED_REGS > 1) ? $clog2(SEED_REGS) : 1;
  localparam int unsigned BITMAP_BYTES = (SENSOR_COUNT + 7) / 8;
  localparam int unsigned BMP_BITS     = BITMAP_BYTES * 8;
  localparam int unsigned BMP_IDX_W    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned ACC_W        = MAX_WIDTH + 8;
  localparam int unsigned CNT_W        = $clog2(ACC_W);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENTINEL   = 3'd0,
    CFG_SEED_ZERO  = 3'd1,
    CFG_SEED_ONE   = 3'd2,
    CFG_SEED_TWO   = 3'd3,
    CFG_SEED_THREE = 3'd4,
    CFG_SEED_FOUR  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEC_BITMAP = 2'd0,
    SEC_BODY   = 2'd1,
    SEC_CRC    = 2'd2
  } section_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_START,
    ST_BITMAP,
    ST_BODY,
    ST_CRC_LO,
    ST_CRC_HI
  } back_state_e;

  typedef struct packed {
    logic [5:0]  field_width;
    logic [31:0] sensor_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    section_e   section;
    logic       last_byte;
  } out_item_t;

  // classified record as it travels from the front to the back
  typedef struct packed {
    logic [5:0]  width;
    logic [31:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [31:0]                 sentinel;
    logic [SEED_REGS-1:0][15:0] seeds;
  } cfg_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/spf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire spf_pkg::rec_t push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output spf_pkg::rec_t     pop_data_o
);
  import spf_pkg::*;

  rec_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/spf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire spf_pkg::in_item_t in_i,
  output logic                  busy_o,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output spf_pkg::rec_t         q_rec_o
);
  import spf_pkg::*;

  logic [IDX_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [5:0]       width_sat;
  logic             accept;
  logic             is_last;

  assign busy_o   = q_full_i;
  assign accept   = start_i && !q_full_i;
  assign q_push_o = accept;
  assign is_last  = (rec_cnt_q == IDX_W'(SENSOR_COUNT - 1));

  // widths above the word saturate, the raw value is kept for the presence test
  always_comb begin
    width_sat  = (in_i.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_i.field_width;
    q_rec_o.width = width_sat;
    q_rec_o.value = in_i.sensor_value;
    q_rec_o.last  = is_last;
  end

  always_comb begin
    rec_cnt_d = rec_cnt_q;
    if (accept) begin
      rec_cnt_d = is_last ? '0 : rec_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q <= '0;
    end else begin
      rec_cnt_q <= rec_cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/spf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire spf_pkg::cfg_t cfg_i,
  input  wire logic          q_empty_i,
  input  wire spf_pkg::rec_t q_data_i,
  output logic               q_pop_o,
  output logic               out_strobe_o,
  output spf_pkg::out_item_t out_o
);
  import spf_pkg::*;

  back_state_e state_q, state_d;

  logic [5:0]  width_q [SENSOR_COUNT];
  logic [31:0] value_q [SENSOR_COUNT];
  logic        st_we;

  logic [IDX_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]      sens_q, sens_d;
  logic                  body_done_q, body_done_d;
  logic [SENSOR_COUNT-1:0] pres_q, pres_d;
  logic [BMP_BITS-1:0]   bmp_q, bmp_d;
  logic [BMP_IDX_W-1:0]  bmp_cnt_q, bmp_cnt_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [15:0]           crc_q, crc_d;
  logic [SEED_IDX_W-1:0] seed_idx_q, seed_idx_d;
  logic                  strobe_q, strobe_d;
  out_item_t             out_q, out_d;

  logic                  emit;
  logic [7:0]            emit_byte;
  section_e              emit_sec;
  logic                  emit_last;
  logic [ACC_W-1:0]      acc_shr;
  logic [2:0]            flush_sh;
  logic [31:0]           body_val;

  assign out_strobe_o = strobe_q;
  assign out_o        = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (!q_empty_i && q_data_i.last) state_d = ST_START;
      end
      ST_START:  state_d = ST_BITMAP;
      ST_BITMAP: begin
        if (bmp_cnt_q == BMP_IDX_W'(BITMAP_BYTES - 1)) state_d = ST_BODY;
      end
      ST_BODY: begin
        if (body_done_q && (cnt_q < CNT_W'(8))) state_d = ST_CRC_LO;
      end
      ST_CRC_LO: state_d = ST_CRC_HI;
      ST_CRC_HI: state_d = ST_COLLECT;
      default:   state_d = ST_COLLECT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    sens_d      = sens_q;
    body_done_d = body_done_q;
    pres_d      = pres_q;
    bmp_d       = bmp_q;
    bmp_cnt_d   = bmp_cnt_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    seed_idx_d  = seed_idx_q;
    q_pop_o     = 1'b0;
    st_we       = 1'b0;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_sec    = SEC_BITMAP;
    emit_last   = 1'b0;
    acc_shr     = acc_q >> (cnt_q - CNT_W'(8));
    flush_sh    = 3'(4'd8 - cnt_q[3:0]);
    // only the low width bits of a value are packed
    body_val    = value_q[sens_q] & 32'((33'd1 << width_q[sens_q]) - 33'd1);

    unique case (state_q)
      ST_COLLECT: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          st_we    = 1'b1;
          wr_ptr_d = q_data_i.last ? '0 : wr_ptr_q + 1'b1;
        end
      end
      ST_START: begin
        crc_d      = cfg_i.seeds[seed_idx_q];
        seed_idx_d = (seed_idx_q == SEED_IDX_W'(SEED_COUNT - 1)) ? '0 : seed_idx_q + 1'b1;
        bmp_d      = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          pres_d[i]              = (value_q[i] != cfg_i.sentinel);
          bmp_d[BMP_BITS - 1 - i] = (value_q[i] != cfg_i.sentinel);
        end
        bmp_cnt_d   = '0;
        sens_d      = '0;
        body_done_d = 1'b0;
        acc_d       = '0;
        cnt_d       = '0;
      end
      ST_BITMAP: begin
        emit      = 1'b1;
        emit_byte = bmp_q[BMP_BITS-1 -: 8];
        emit_sec  = SEC_BITMAP;
        bmp_d     = bmp_q << 8;
        bmp_cnt_d = bmp_cnt_q + 1'b1;
      end
      ST_BODY: begin
        if (cnt_q >= CNT_W'(8)) begin
          // a whole byte is waiting in the accumulator
          emit      = 1'b1;
          emit_byte = acc_shr[7:0];
          emit_sec  = SEC_BODY;
          cnt_d     = cnt_q - CNT_W'(8);
        end else if (!body_done_q) begin
          // absent sensors are skipped, present ones append their bits
          if (pres_q[sens_q]) begin
            acc_d = (acc_q << width_q[sens_q]) | ACC_W'(body_val);
            cnt_d = cnt_q + CNT_W'(width_q[sens_q]);
          end
          if (sens_q == IDX_W'(SENSOR_COUNT - 1)) begin
            body_done_d = 1'b1;
          end else begin
            sens_d = sens_q + 1'b1;
          end
        end else if (cnt_q != '0) begin
          // zero padded tail byte
          emit      = 1'b1;
          emit_byte = acc_q[7:0] << flush_sh;
          emit_sec  = SEC_BODY;
          cnt_d     = '0;
        end
      end
      ST_CRC_LO: begin
        emit      = 1'b1;
        emit_byte = crc_q[7:0];
        emit_sec  = SEC_CRC;
      end
      ST_CRC_HI: begin
        emit      = 1'b1;
        emit_byte = crc_q[15:8];
        emit_sec  = SEC_CRC;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase

    if (emit && (emit_sec != SEC_CRC)) begin
      crc_d = crc_step(crc_q, emit_byte);
    end
    strobe_d = emit;
    out_d    = out_q;
    if (emit) begin
      out_d.out_byte  = emit_byte;
      out_d.section   = emit_sec;
      out_d.last_byte = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      wr_ptr_q    <= '0;
      sens_q      <= '0;
      body_done_q <= 1'b0;
      bmp_cnt_q   <= '0;
      cnt_q       <= '0;
      crc_q       <= '0;
      seed_idx_q  <= '0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      sens_q      <= sens_d;
      body_done_q <= body_done_d;
      bmp_cnt_q   <= bmp_cnt_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      seed_idx_q  <= seed_idx_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pres_q <= pres_d;
    bmp_q  <= bmp_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
    if (st_we) begin
      width_q[wr_ptr_q] <= q_data_i.width;
      value_q[wr_ptr_q] <= q_data_i.value;
    end
  end

endmodule

`default_nettype wire

// File: sv/sensor_packet_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                               | handshake
// ----------+-------------------------------------+-------------------------------------
// request   | in_i (field_width, sensor_value)    | taken when start_i high, busy_o low
// result    | out_o (out_byte, section, last_byte)| out_strobe_o, one cycle, no stall
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i    | written on any edge with cfg_we_i
//
// a request is classified in the front (width saturation, packet close tag)
// and is pushed straight into a two-entry queue; the back drains the
// queue into the record store at one request per cycle while collecting
// a packet of N = 8 requests, then opens it (seed load, bitmap), sends the
// bitmap bytes, packs the present sensors in turn, sending body bytes as
// the accumulator fills and a zero padded tail byte unless the body ends on
// a byte boundary, then the two crc bytes; at most one byte per cycle
// reset is asynchronous and clears control state; the record store is not cleared
// results cannot be held off; busy_o rises only when the queue is full while
// the back end is busy emitting a packet

module sensor_packet_framer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire spf_pkg::in_item_t                in_i,
  output logic                                  busy_o,
  output logic                                  out_strobe_o,
  output spf_pkg::out_item_t                    out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [spf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [spf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import spf_pkg::*;

  `include "sensor_packet_framer_assert.svh"

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // front to queue to back
  logic q_full, q_empty, q_push, q_pop;
  rec_t q_in_rec, q_out_rec;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      // indexes past the last seed are ignored
      case (cfg_idx_i)
        CFG_SENTINEL:   cfg_d.sentinel = cfg_wdata_i;
        CFG_SEED_ZERO:  cfg_d.seeds[0] = cfg_wdata_i[15:0];
        CFG_SEED_ONE:   cfg_d.seeds[1] = cfg_wdata_i[15:0];
        CFG_SEED_TWO:   cfg_d.seeds[2] = cfg_wdata_i[15:0];
        CFG_SEED_THREE: cfg_d.seeds[3] = cfg_wdata_i[15:0];
        CFG_SEED_FOUR:  cfg_d.seeds[4] = cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sentinel <= '1;
      cfg_q.seeds    <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: takes requests and classifies them
  spf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .busy_o   (busy_o),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_rec_o  (q_in_rec)
  );

  // short queue so front and back stall independently
  spf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in_rec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out_rec)
  );

  // back: record store, bit packer and crc
  spf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out_rec),
    .q_pop_o      (q_pop),
    .out_strobe_o (out_strobe_o),
    .out_o        (out_o)
  );

  // final byte of a packet is always a crc byte
  `SPF_ASSERT(a_last_is_crc, out_strobe_o && out_o.last_byte |-> out_o.section == SEC_CRC)
  // low crc byte is followed directly by the high one
  `SPF_ASSERT(a_crc_pair, out_strobe_o && out_o.section == SEC_CRC && !out_o.last_byte |=> out_strobe_o && out_o.last_byte)
  // a packet end leaves a gap before anything else is sent
  `SPF_ASSERT(a_gap_after_last, out_strobe_o && out_o.last_byte |=> !out_strobe_o)

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import spf_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  // margin waited out after the last expected byte has arrived
  localparam int DRAIN_CYCLES = 64;
  // overall run limit, sized to cover every packet and the settle pauses
  localparam int CYCLE_LIMIT  = 200000;
  // register indexes past the last seed register, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // expected packet bytes, built from the requests the block has taken
  class packet_tracker;
    logic [31:0]  sentinel;
    logic [15:0]  seed_reg [SEED_REGS];
    logic [5:0]   width_slot [SENSOR_COUNT];
    logic [31:0]  value_slot [SENSOR_COUNT];
    int unsigned  slots_filled;
    int unsigned  seed_sel;
    logic [15:0]  crc;
    logic [7:0]   shift_byte;
    int unsigned  shift_bits;
    int unsigned  mismatches;
    int unsigned  bytes_checked;
    out_item_t    pending_bytes [$];

    function new();
      sentinel = 32'hFFFF_FFFF;
      foreach (seed_reg[i]) seed_reg[i] = 16'hFFFF;
      slots_filled  = 0;
      seed_sel      = 0;
      mismatches    = 0;
      bytes_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_SENTINEL) begin
        sentinel = data;
      end else if (idx >= CFG_SEED_ZERO && idx <= CFG_SEED_FOUR) begin
        seed_reg[idx - CFG_SEED_ZERO] = data[15:0];
      end
    endfunction

    // queue one byte; bitmap and body bytes also run through the crc
    function void put_byte(logic [7:0] data, section_e sec, logic last);
      out_item_t e;
      e.out_byte  = data;
      e.section   = sec;
      e.last_byte = last;
      pending_bytes.push_back(e);
      if (sec != SEC_CRC) begin
        for (int i = 7; i >= 0; i--) begin
          crc = {crc[14:0], 1'b0} ^ ((crc[15] ^ data[i]) ? CRC_POLY : 16'h0000);
        end
      end
    endfunction

    function void put_bit(logic bit_v, section_e sec);
      shift_byte = {shift_byte[6:0], bit_v};
      shift_bits++;
      if (shift_bits == 8) begin
        put_byte(shift_byte, sec, 1'b0);
        shift_byte = '0;
        shift_bits = 0;
      end
    endfunction

    // pad a partial byte with zeros at the bottom
    function void flush(section_e sec);
      if (shift_bits != 0) begin
        put_byte(shift_byte << (8 - shift_bits), sec, 1'b0);
        shift_byte = '0;
        shift_bits = 0;
      end
    endfunction

    function void note_request(in_item_t r);
      logic [5:0] w;
      w = (r.field_width > 6'd32) ? 6'd32 : r.field_width;
      width_slot[slots_filled] = w;
      value_slot[slots_filled] = r.sensor_value;
      slots_filled++;
      if (slots_filled < SENSOR_COUNT) return;
      slots_filled = 0;
      crc        = seed_reg[seed_sel];
      seed_sel   = (seed_sel + 1) % SEED_COUNT;
      shift_byte = '0;
      shift_bits = 0;
      foreach (value_slot[i]) put_bit(value_slot[i] != sentinel, SEC_BITMAP);
      flush(SEC_BITMAP);
      foreach (value_slot[i]) begin
        if (value_slot[i] != sentinel) begin
          for (int b = width_slot[i]; b > 0; b--) put_bit(value_slot[i][b-1], SEC_BODY);
        end
      end
      flush(SEC_BODY);
      put_byte(crc[7:0], SEC_CRC, 1'b0);
      put_byte(crc[15:8], SEC_CRC, 1'b1);
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: byte with none expected, actual byte %h section %0d last %0b",
                 $time, got.out_byte, got.section, got.last_byte);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        $display("%0t: out_byte mismatch, expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.section !== want.section) begin
        mismatches++;
        $display("%0t: section mismatch, expected %0d, actual %0d",
                 $time, want.section, got.section);
      end
      if (got.last_byte !== want.last_byte) begin
        mismatches++;
        $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                 $time, want.last_byte, got.last_byte);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  in_item_t             in_i;
  logic                 busy_o;
  logic                 out_strobe_o;
  out_item_t            out_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_wdata_i;

  packet_tracker chk = new();
  logic [31:0]   cur_sentinel = 32'hFFFF_FFFF;
  int unsigned   requests_sent = 0;
  int unsigned   cycle_count = 0;

  sensor_packet_framer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .in_i         (in_i),
    .busy_o       (busy_o),
    .out_strobe_o (out_strobe_o),
    .out_o        (out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // results cannot be stalled, so every strobe is checked at the edge it ends on
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) chk.check_byte(out_o);
  end

  // hard stop in case the block hangs or drops a packet
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, chk.pending_bytes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // one register write; called at a falling edge, returns at the next one
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    chk.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // full register setting: sentinel, five seeds, then the spare indexes
  // upper bits of seed writes carry noise that the block must drop
  task automatic program_regs(logic [31:0] sentinel, logic [SEED_REGS-1:0][15:0] seeds);
    reg_write(CFG_SENTINEL, sentinel);
    for (int i = 0; i < SEED_REGS; i++) begin
      reg_write(CFG_IDX_W'(CFG_SEED_ZERO + i), {16'($urandom()), seeds[i]});
    end
    reg_write(CFG_SPARE_LO, $urandom());
    reg_write(CFG_SPARE_HI, $urandom());
    cfg_we_i     <= 1'b0;
    cur_sentinel  = sentinel;
    @(negedge clk_i);
  endtask

  // one sensor record; an optional idle burst first, then hold start
  // until the block takes it
  task automatic send_request(in_item_t item, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    chk.note_request(item);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // mostly plain widths, some saturating ones, and a share of absent sensors
  function automatic in_item_t random_record();
    in_item_t r;
    r.field_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
    case ($urandom_range(0, 9))
      0, 1:    r.sensor_value = cur_sentinel;
      2:       r.sensor_value = 32'h0000_0000;
      3:       r.sensor_value = 32'hFFFF_FFFF;
      default: r.sensor_value = $urandom();
    endcase
    return r;
  endfunction

  task automatic send_random_packets(int count, bit gaps);
    repeat (count * SENSOR_COUNT) send_request(random_record(), gaps);
  endtask

  // let the last packet drain before any register changes
  task automatic settle();
    start_i <= 1'b0;
    while (chk.pending_bytes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [SEED_REGS-1:0][15:0] seeds;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SENTINEL;
    cfg_wdata_i <= '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: sentinel all ones, every seed 0xffff
    // mixed packet: zero width, full width, saturated widths, an absent sensor
    send_request('{6'd0,  32'h1234_5678}, 1'b0);
    send_request('{6'd32, 32'hFFFF_FFFF}, 1'b0);
    send_request('{6'd33, 32'hFFFF_FFFE}, 1'b0);
    send_request('{6'd63, 32'h8000_0001}, 1'b0);
    send_request('{6'd1,  32'h0000_0000}, 1'b0);
    send_request('{6'd31, 32'h7FFF_FFFF}, 1'b0);
    send_request('{6'd7,  32'h0000_00A5}, 1'b0);
    send_request('{6'd8,  32'h0000_005A}, 1'b0);
    // every sensor absent: zero bitmap, no body bytes
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      send_request('{6'($urandom_range(0, 63)), 32'hFFFF_FFFF}, 1'b0);
    end
    // every sensor present at zero width: full bitmap, still no body
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      send_request('{6'd0, 32'(i)}, 1'b0);
    end
    send_random_packets(4, 1'b1);
    settle();

    // low extreme: sentinel zero, zero seeds
    program_regs(32'h0000_0000, '0);
    send_random_packets(4, 1'b1);
    settle();

    // random sentinel and seeds
    for (int i = 0; i < SEED_REGS; i++) seeds[i] = 16'($urandom());
    program_regs($urandom(), seeds);
    send_random_packets(4, 1'b1);
    settle();

    // high extreme written explicitly, closing stretch at full rate
    program_regs(32'hFFFF_FFFF, '1);
    send_random_packets(2, 1'b1);
    send_random_packets(3, 1'b0);
    settle();

    $display("ran %0d packets from %0d sensor records, %0d packet bytes checked",
             requests_sent / SENSOR_COUNT, requests_sent, chk.bytes_checked);
    $display("settings: reset values, all zero, random, all ones; spare indexes written");
    if (chk.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
